@@ design/ttcs_pkg.sv @@
// Shared types and constants for the text terminal with cursor and scroll.
// Used by ttcs_ctrl, ttcs_datapath and text_terminal_cursor_scroll.
package ttcs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int IDX_W  = 11;
  localparam int SUM_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic       CMD_PUT      = 1'b0;
  localparam logic       CMD_READ     = 1'b1;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [15:0] RESET_BLANK  = 16'h0120;
  localparam logic [15:0] SCROLL_BLANK = 16'h0220;
  localparam logic [7:0] ATTR_RESET   = 8'h01;

  typedef struct packed {
    logic             command;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } out_item_t;

  typedef struct packed {
    logic init_step;
    logic take_item;
    logic scroll_step;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic scroll_last;
    logic item_scrolls;
    logic result_free;
  } dp_status_t;

endpackage

@@ design/ttcs_ctrl.sv @@
// Sequencer for the text terminal: clearing pass, item accept, row clear on
// scroll and result hand-off. Depends on ttcs_pkg.
module ttcs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  ttcs_pkg::dp_status_t  status,
  output ttcs_pkg::ctl_cmd_t    ctl
);

  localparam logic [1:0] S_INIT   = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_INIT: begin
        ctl.init_step = 1'b1;
        if (status.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.take_item = 1'b1;
          state_next    = status.item_scrolls ? S_SCROLL : S_RESP;
        end
      end
      S_SCROLL: begin
        ctl.scroll_step = 1'b1;
        if (status.scroll_last) state_next = S_RESP;
      end
      S_RESP: begin
        // hold until the result register can take the beat
        if (status.result_free) begin
          ctl.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  assign cmd_stall = (state != S_IDLE);

endmodule

@@ design/ttcs_datapath.sv @@
// Datapath of the text terminal: screen memory as a ring of rows, cursor,
// attribute register and result register. Depends on ttcs_pkg.
module ttcs_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ttcs_pkg::in_item_t    item,
  input  ttcs_pkg::ctl_cmd_t    ctl,
  output ttcs_pkg::dp_status_t  status,
  input  logic                  attr_we,
  input  logic [7:0]            attr_wdata,
  output logic [7:0]            text_attribute,
  output logic                  res_valid,
  input  logic                  res_stall,
  output ttcs_pkg::out_item_t   res_beat
);

  logic [15:0] screen [ttcs_pkg::CELL_COUNT];

  logic [ttcs_pkg::ROW_W-1:0]  row_pos;
  logic [ttcs_pkg::COL_W-1:0]  col_pos;
  logic [ttcs_pkg::ADDR_W-1:0] row_base;   // row_pos * COLUMNS
  logic [ttcs_pkg::ADDR_W-1:0] top_base;   // memory offset of the top screen row
  logic [ttcs_pkg::ADDR_W-1:0] sweep_cnt;
  logic [15:0]                 rd_data;
  logic                        item_read;
  logic                        item_in_range;
  logic                        item_scrolled;

  logic                        is_put;
  logic                        is_read;
  logic                        is_nl;
  logic                        advance_row;
  logic                        last_row;
  logic [ttcs_pkg::SUM_W-1:0]  put_sum;
  logic [ttcs_pkg::SUM_W-1:0]  rd_sum;
  logic [ttcs_pkg::SUM_W-1:0]  clr_sum;
  logic [ttcs_pkg::ADDR_W-1:0] put_addr;
  logic [ttcs_pkg::ADDR_W-1:0] rd_addr;
  logic                        idx_ok;
  logic                        wr_en;
  logic [ttcs_pkg::ADDR_W-1:0] wr_addr;
  logic [15:0]                 wr_data;
  logic                        rd_en;
  logic                        sweep_last;

  assign is_put  = ctl.take_item && (item.command == ttcs_pkg::CMD_PUT);
  assign is_read = ctl.take_item && (item.command == ttcs_pkg::CMD_READ);
  assign is_nl   = (item.char_code == ttcs_pkg::NEWLINE_CODE);

  assign advance_row = is_nl || (col_pos == ttcs_pkg::COL_W'(ttcs_pkg::COLUMNS - 1));
  assign last_row    = (row_pos == ttcs_pkg::ROW_W'(ttcs_pkg::ROWS - 1));

  // Logical cell plus top offset, folded once into the ring
  assign put_sum  = ttcs_pkg::SUM_W'(row_base) + ttcs_pkg::SUM_W'(col_pos)
                  + ttcs_pkg::SUM_W'(top_base);
  assign put_addr = (put_sum >= ttcs_pkg::SUM_W'(ttcs_pkg::CELL_COUNT))
                  ? ttcs_pkg::ADDR_W'(put_sum - ttcs_pkg::SUM_W'(ttcs_pkg::CELL_COUNT))
                  : ttcs_pkg::ADDR_W'(put_sum);

  assign idx_ok  = ttcs_pkg::SUM_W'(item.cell_index) < ttcs_pkg::SUM_W'(ttcs_pkg::CELL_COUNT);
  assign rd_sum  = ttcs_pkg::SUM_W'(item.cell_index) + ttcs_pkg::SUM_W'(top_base);
  assign rd_addr = (rd_sum >= ttcs_pkg::SUM_W'(ttcs_pkg::CELL_COUNT))
                 ? ttcs_pkg::ADDR_W'(rd_sum - ttcs_pkg::SUM_W'(ttcs_pkg::CELL_COUNT))
                 : ttcs_pkg::ADDR_W'(rd_sum);
  assign rd_en   = is_read && idx_ok;

  // Row leaving the top becomes the new bottom row; top_base is row aligned
  assign clr_sum = ttcs_pkg::SUM_W'(top_base) + ttcs_pkg::SUM_W'(sweep_cnt);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = put_addr;
    wr_data = {text_attribute, item.char_code};
    if (ctl.init_step) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt;
      wr_data = ttcs_pkg::RESET_BLANK;
    end else if (ctl.scroll_step) begin
      wr_en   = 1'b1;
      wr_addr = ttcs_pkg::ADDR_W'(clr_sum);
      wr_data = ttcs_pkg::SCROLL_BLANK;
    end else if (is_put && !is_nl) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) screen[wr_addr] <= wr_data;
    if (rd_en) rd_data <= screen[rd_addr];
  end

  assign sweep_last = ctl.init_step
                    ? (sweep_cnt == ttcs_pkg::ADDR_W'(ttcs_pkg::CELL_COUNT - 1))
                    : (sweep_cnt == ttcs_pkg::ADDR_W'(ttcs_pkg::COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (ctl.init_step || ctl.scroll_step) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos  <= '0;
      col_pos  <= '0;
      row_base <= '0;
    end else if (is_put) begin
      if (advance_row) begin
        col_pos <= '0;
        if (!last_row) begin
          row_pos  <= row_pos + 1'b1;
          row_base <= row_base + ttcs_pkg::ADDR_W'(ttcs_pkg::COLUMNS);
        end
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_base <= '0;
    end else if (ctl.scroll_step && sweep_last) begin
      if (top_base == ttcs_pkg::ADDR_W'(ttcs_pkg::CELL_COUNT - ttcs_pkg::COLUMNS)) begin
        top_base <= '0;
      end else begin
        top_base <= top_base + ttcs_pkg::ADDR_W'(ttcs_pkg::COLUMNS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ttcs_pkg::ATTR_RESET;
    end else if (attr_we) begin
      text_attribute <= attr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      item_read     <= is_read;
      item_in_range <= idx_ok;
      item_scrolled <= is_put && advance_row && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      res_beat.cell_data  <= (item_read && item_in_range) ? rd_data : 16'h0000;
      res_beat.cursor_row <= 5'(row_pos);
      res_beat.cursor_col <= 7'(col_pos);
      res_beat.scrolled   <= item_scrolled;
    end
  end

  // Status is taken from registers, the offered item and res_stall only, never from ctl
  assign status.init_last    = (sweep_cnt == ttcs_pkg::ADDR_W'(ttcs_pkg::CELL_COUNT - 1));
  assign status.scroll_last  = (sweep_cnt == ttcs_pkg::ADDR_W'(ttcs_pkg::COLUMNS - 1));
  assign status.item_scrolls = (item.command == ttcs_pkg::CMD_PUT) && advance_row && last_row;
  assign status.result_free  = !res_valid || !res_stall;

endmodule

@@ design/text_terminal_cursor_scroll.sv @@
// Character-cell text terminal, 80 x 25 cells of {attribute, character}.
// Depends on ttcs_pkg, ttcs_ctrl and ttcs_datapath.
//
// Use:
//   cmd channel (cmd_valid / cmd_stall / cmd_beat) takes put and read items;
//   res channel (res_valid / res_stall / res_beat) returns one beat per item
//   with the cell read (zero for puts), the cursor and the scroll flag.
//   The APB port holds the text attribute register at address 0.
// Timing:
//   An item is taken in the idle state and its result is loaded into the
//   result register from the response state once that register is free;
//   a held result can delay the load. A put that scrolls first clears the
//   new bottom row in the scroll state, one cell a cycle. The screen is a
//   ring of rows in one memory with one write and one read port.
// Reset:
//   A clearing pass writes every cell blank with cmd_stall high; APB
//   writes are taken throughout.
// Stall:
//   A held result stays in the result register; the block then waits with
//   cmd_stall high until the beat is taken or the register frees up.
module text_terminal_cursor_scroll (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  ttcs_pkg::in_item_t   cmd_beat,
  output logic                 res_valid,
  input  logic                 res_stall,
  output ttcs_pkg::out_item_t  res_beat,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  ttcs_pkg::ctl_cmd_t   ctl;
  ttcs_pkg::dp_status_t status;
  logic [7:0]           text_attribute;
  logic                 attr_we;
  logic                 attr_sel;

  assign pready   = 1'b1;
  assign attr_sel = (paddr[2] == REG_TEXT_ATTRIBUTE);
  assign attr_we  = psel && penable && pwrite && attr_sel;
  assign prdata   = attr_sel ? {24'h000000, text_attribute} : 32'h00000000;

  ttcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .status    (status),
    .ctl       (ctl)
  );

  ttcs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .item           (cmd_beat),
    .ctl            (ctl),
    .status         (status),
    .attr_we        (attr_we),
    .attr_wdata     (pwdata[7:0]),
    .text_attribute (text_attribute),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res_beat       (res_beat)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for text_terminal_cursor_scroll: directed table, then random bursts.
// Depends on ttcs_pkg and the design files; keeps its own shadow of the screen and the cursor.
`timescale 1ns / 100ps
module tb;

  localparam logic [2:0] ATTR_ADDR      = 3'd0;
  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         HOLD_LEN       = 400;
  localparam int         RANDOM_ITEMS   = 1330;
  localparam int         PHASES         = 5;
  localparam int         SETTLE         = ttcs_pkg::COLUMNS + 20;
  localparam int         IDX_MAX        = (1 << ttcs_pkg::IDX_W) - 1;
  localparam int         DIR_ROWS       = 22;

  typedef struct {
    ttcs_pkg::in_item_t  item;
    bit                  typed;
    ttcs_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  ttcs_pkg::in_item_t  cmd_beat = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  ttcs_pkg::out_item_t res_beat;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  text_terminal_cursor_scroll dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_beat(cmd_beat),
    .res_valid(res_valid), .res_stall(res_stall), .res_beat(res_beat),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the terminal
  logic [15:0] shadow_screen [ttcs_pkg::CELL_COUNT];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  shadow_attr;

  ttcs_pkg::out_item_t terminal_results_q [$];
  int          errors = 0;
  int          items_sent = 0;
  int          reads_sent = 0;
  int          scrolls_seen = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  // receiver stall shaping
  int          stall_left = 0;
  int          free_left = 0;
  int          hold_at = 250;
  int          chk_r;
  ttcs_pkg::out_item_t chk_want;

  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd0},    1'b1, '{16'h0120, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'hFF, 11'd1999}, 1'b1, '{16'h0120, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd2000}, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd2047}, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'h41, 11'h7FF},  1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd0},    1'b1, '{16'h0141, 5'd0, 7'd1, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'h00, 11'd0},    1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'hFF, 11'd0},    1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'h0D, 11'd0},    1'b1, '{16'h0000, 5'd0, 7'd4, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd3},    1'b1, '{16'h010D, 5'd0, 7'd4, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd2},    1'b1, '{16'h01FF, 5'd0, 7'd4, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd1},    1'b1, '{16'h0100, 5'd0, 7'd4, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT, ttcs_pkg::NEWLINE_CODE, 11'h555}, 1'b1,
      '{16'h0000, 5'd1, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT, ttcs_pkg::NEWLINE_CODE, 11'h2AA}, 1'b1,
      '{16'h0000, 5'd2, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd80},   1'b1, '{16'h0120, 5'd2, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'h20, 11'd0},    1'b1, '{16'h0000, 5'd2, 7'd1, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd160},  1'b1, '{16'h0120, 5'd2, 7'd1, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, ttcs_pkg::NEWLINE_CODE, 11'd5}, 1'b1,
      '{16'h0120, 5'd2, 7'd1, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd1040}, 1'b0, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'hAA, 11'd0},    1'b0, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_PUT,  8'h55, 11'd0},    1'b0, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{'{ttcs_pkg::CMD_READ, 8'h00, 11'd162},  1'b0, '{16'h0000, 5'd0, 7'd0, 1'b0}}
  };

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 50)
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
  endtask

  // Apply one item to the shadow terminal and return the beat it should produce.
  function automatic ttcs_pkg::out_item_t terminal_advance(input ttcs_pkg::in_item_t it);
    ttcs_pkg::out_item_t o;
    int                  pos;
    o = '0;
    if (it.command == ttcs_pkg::CMD_READ) begin
      if (int'(it.cell_index) < ttcs_pkg::CELL_COUNT)
        o.cell_data = shadow_screen[it.cell_index];
    end else begin
      if (it.char_code == ttcs_pkg::NEWLINE_CODE) begin
        shadow_row++;
        shadow_col = 0;
      end else begin
        pos = shadow_row * ttcs_pkg::COLUMNS + shadow_col;
        if (pos < ttcs_pkg::CELL_COUNT) shadow_screen[pos] = {shadow_attr, it.char_code};
        shadow_col++;
        if (shadow_col >= ttcs_pkg::COLUMNS) begin
          shadow_col = 0;
          shadow_row++;
        end
      end
      if (shadow_row >= ttcs_pkg::ROWS) begin
        for (int k = 0; k < ttcs_pkg::CELL_COUNT - ttcs_pkg::COLUMNS; k++)
          shadow_screen[k] = shadow_screen[k + ttcs_pkg::COLUMNS];
        for (int k = ttcs_pkg::CELL_COUNT - ttcs_pkg::COLUMNS; k < ttcs_pkg::CELL_COUNT; k++)
          shadow_screen[k] = ttcs_pkg::SCROLL_BLANK;
        shadow_row = ttcs_pkg::ROWS - 1;
        o.scrolled = 1'b1;
      end
    end
    o.cursor_row = shadow_row[4:0];
    o.cursor_col = shadow_col[6:0];
    return o;
  endfunction

  // Offer one beat, hold it until taken, then idle for a random gap.
  task automatic send_beat(input ttcs_pkg::in_item_t it, input bit typed,
                           input ttcs_pkg::out_item_t want);
    ttcs_pkg::out_item_t predicted;
    int                  gap;
    int                  r;
    cmd_valid <= 1'b1;
    cmd_beat  <= it;
    do @(posedge clk); while (cmd_stall);
    predicted = terminal_advance(it);
    terminal_results_q.push_back(typed ? want : predicted);
    items_sent++;
    if (it.command == ttcs_pkg::CMD_READ) reads_sent++;
    if (predicted.scrolled) scrolls_seen++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = int'($urandom_range(0, 99));
      if (r < 45) gap = 0;
      else if (r < 80) gap = int'($urandom_range(1, 3));
      else if (r < 95) gap = int'($urandom_range(4, 12));
      else if (r < 98) gap = int'($urandom_range(20, 60));
      else begin
        burst_left = int'($urandom_range(30, 120));
        gap = 0;
      end
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check each result beat, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (terminal_results_q.size() == 0) begin
        report_mismatch("beat with nothing expected", 32'(res_beat), 32'd0);
      end else begin
        chk_want = terminal_results_q.pop_front();
        if (res_beat.cell_data != chk_want.cell_data)
          report_mismatch("cell_data", 32'(res_beat.cell_data), 32'(chk_want.cell_data));
        if (res_beat.cursor_row != chk_want.cursor_row)
          report_mismatch("cursor_row", 32'(res_beat.cursor_row), 32'(chk_want.cursor_row));
        if (res_beat.cursor_col != chk_want.cursor_col)
          report_mismatch("cursor_col", 32'(res_beat.cursor_col), 32'(chk_want.cursor_col));
        if (res_beat.scrolled != chk_want.scrolled)
          report_mismatch("scrolled", 32'(res_beat.scrolled), 32'(chk_want.scrolled));
      end
      results_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if (results_seen >= hold_at) begin
      // long hold-off: let the block back up into its input
      hold_at += 600;
      stall_left = HOLD_LEN - 1;
      res_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      res_stall <= 1'b0;
    end else begin
      chk_r = int'($urandom_range(0, 99));
      free_left = (chk_r < 10) ? int'($urandom_range(100, 300)) : int'($urandom_range(0, 12));
      chk_r = int'($urandom_range(0, 99));
      stall_left = (chk_r < 90) ? int'($urandom_range(1, 3)) : int'($urandom_range(15, 60));
      res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, terminal_results_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    ttcs_pkg::in_item_t  it;
    ttcs_pkg::out_item_t none;
    int                  kind;
    int                  len;
    int                  target;
    logic [7:0]          attr_plan [0:PHASES-1];
    none = '0;
    it   = '0;
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = 8'($urandom_range(0, 255));
    attr_plan[3] = 8'hA5;
    attr_plan[4] = 8'($urandom_range(0, 255));
    foreach (shadow_screen[k]) shadow_screen[k] = ttcs_pkg::RESET_BLANK;
    shadow_row  = 0;
    shadow_col  = 0;
    shadow_attr = ttcs_pkg::ATTR_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) send_beat(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
    cmd_valid <= 1'b0;

    target = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      // pause until the block has drained, then retune the attribute
      while (terminal_results_q.size() != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ATTR_ADDR;
      pwdata  <= {24'h0, attr_plan[p]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      shadow_attr = attr_plan[p];
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata != {24'h0, attr_plan[p]})
        report_mismatch("text_attribute readback", prdata, {24'h0, attr_plan[p]});
      psel    <= 1'b0;
      penable <= 1'b0;

      target += RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        kind = int'($urandom_range(0, 99));
        if (kind < 50) begin
          // short line ended by a newline
          len = int'($urandom_range(0, 14));
          it.command = ttcs_pkg::CMD_PUT;
          repeat (len) begin
            it.char_code  = 8'($urandom_range(0, 255));
            it.cell_index = ttcs_pkg::IDX_W'($urandom_range(0, IDX_MAX));
            send_beat(it, 1'b0, none);
          end
          it.char_code  = ttcs_pkg::NEWLINE_CODE;
          it.cell_index = ttcs_pkg::IDX_W'($urandom_range(0, IDX_MAX));
          send_beat(it, 1'b0, none);
        end else if (kind < 58) begin
          // long run of characters that can wrap at the right edge
          len = int'($urandom_range(60, 170));
          it.command = ttcs_pkg::CMD_PUT;
          repeat (len) begin
            it.char_code  = 8'($urandom_range(0, 255));
            it.cell_index = ttcs_pkg::IDX_W'($urandom_range(0, IDX_MAX));
            send_beat(it, 1'b0, none);
          end
        end else if (kind < 88) begin
          len = int'($urandom_range(1, 8));
          it.command = ttcs_pkg::CMD_READ;
          repeat (len) begin
            it.char_code = 8'($urandom_range(0, 255));
            kind = int'($urandom_range(0, 9));
            if (kind < 4)
              it.cell_index = ttcs_pkg::IDX_W'(shadow_row * ttcs_pkg::COLUMNS
                              + int'($urandom_range(0, ttcs_pkg::COLUMNS - 1)));
            else if (kind < 8)
              it.cell_index = ttcs_pkg::IDX_W'($urandom_range(0, ttcs_pkg::CELL_COUNT - 1));
            else
              it.cell_index = ttcs_pkg::IDX_W'($urandom_range(ttcs_pkg::CELL_COUNT, IDX_MAX));
            send_beat(it, 1'b0, none);
          end
        end else begin
          it.command    = 1'($urandom_range(0, 1));
          it.char_code  = 8'($urandom_range(0, 255));
          it.cell_index = ttcs_pkg::IDX_W'($urandom_range(0, IDX_MAX));
          send_beat(it, 1'b0, none);
        end
      end
      cmd_valid <= 1'b0;
    end

    while (terminal_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("ran %0d items (%0d reads, %0d puts) with %0d scrolls", items_sent, reads_sent,
             items_sent - reads_sent, scrolls_seen);
    $display("over %0d attribute settings, %0d result beats checked, %0d mismatches",
             PHASES + 1, results_seen, errors);
    if (errors == 0 && terminal_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
